// ===== hw/rtl/slc_pkg.sv =====
// shared types and constants for the source line classifier
// used by slc_line_core and source_line_classifier_unit
package slc_pkg;

    localparam int MAX_LINE   = 500;
    localparam int COUNT_BITS = 24;
    localparam int LEN_BITS   = $clog2(MAX_LINE + 1);
    localparam int N_COUNTERS = 8;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;

    localparam int K_LINES        = 0;
    localparam int K_BYTES        = 1;
    localparam int K_BLANK        = 2;
    localparam int K_CODE         = 3;
    localparam int K_COMMENT      = 4;
    localparam int K_COMMENT_ONLY = 5;
    localparam int K_CODE_ONLY    = 6;
    localparam int K_BOTH         = 7;

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [LEN_BITS-1:0]   t_len;

    typedef struct packed {
        t_cnt [N_COUNTERS-1:0] cnt;
        t_len                  longest;
        logic                  block_open;
    } t_totals;

endpackage

// ===== hw/rtl/slc_line_core.sv =====
// per-byte line state, comment tracking and saturating line counters
// depends on slc_pkg
module slc_line_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_eof,
    output slc_pkg::t_totals o_totals
);
    import slc_pkg::*;

    typedef struct packed {
        logic code;
        logic comment;
        logic nonblank;
        logic eol;
        logic nul;
    } t_flags;

    typedef struct packed {
        logic   bc;
        t_flags f;
        logic   pair;
    } t_exam;

    function automatic t_exam examine(input logic [7:0] c, input logic [7:0] nxt,
                                      input logic has_next, input logic bc,
                                      input t_flags f);
        t_exam r;
        logic  blank;
        r.bc   = bc;
        r.f    = f;
        r.pair = 1'b0;
        blank  = (c == CH_TAB) || (c == CH_SPACE);
        if (bc) begin
            r.f.comment = 1'b1;
        end
        if (has_next) begin
            if (c == CH_SLASH && nxt == CH_STAR) begin
                r.bc        = 1'b1;
                r.f.comment = 1'b1;
                r.pair      = 1'b1;
            end
            if (c == CH_STAR && nxt == CH_SLASH) begin
                r.bc        = 1'b0;
                r.f.comment = 1'b1;
                r.pair      = 1'b1;
            end
            if (c == CH_SLASH && nxt == CH_SLASH) begin
                r.f.eol     = 1'b1;
                r.f.comment = 1'b1;
                r.pair      = 1'b1;
            end
        end
        if (!r.pair && !r.bc && !r.f.eol && !blank) begin
            r.f.code = 1'b1;
        end
        if (!blank) begin
            r.f.nonblank = 1'b1;
        end
        return r;
    endfunction

    function automatic t_cnt sat_add(input t_cnt v, input t_len amt);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, v} + (COUNT_BITS + 1)'(amt);
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    logic                  r_bc, n_bc;
    logic [7:0]            r_held, n_held;
    logic                  r_held_v, n_held_v;
    t_len                  r_len, n_len;
    t_flags                r_flags, n_flags;
    t_cnt [N_COUNTERS-1:0] r_cnt, n_cnt;
    t_len                  r_max, n_max;

    t_exam s_ex;
    t_exam s_pair_ex;
    logic  s_code;
    logic  s_comment;

    always_comb begin
        s_ex = examine(r_held, CH_NUL, 1'b0, r_bc, r_flags);
        if (!r_held_v) begin
            s_ex = '{bc: r_bc, f: r_flags, pair: 1'b0};
        end
        s_pair_ex = examine(r_held, i_byte, 1'b1, r_bc, r_flags);
        s_code    = s_ex.f.code;
        s_comment = s_ex.f.comment;
    end

    always_comb begin
        n_bc     = r_bc;
        n_held   = r_held;
        n_held_v = r_held_v;
        n_len    = r_len;
        n_flags  = r_flags;
        n_cnt    = r_cnt;
        n_max    = r_max;
        if (i_step) begin
            if (i_eof) begin
                n_bc     = 1'b0;
                n_held   = '0;
                n_held_v = 1'b0;
                n_len    = '0;
                n_flags  = '0;
                n_cnt    = '0;
                n_max    = '0;
            end else if (r_len >= t_len'(MAX_LINE) || i_byte == CH_LF) begin
                // line ends: flush the held byte, then classify
                n_bc = s_ex.bc;
                n_cnt[K_LINES] = sat_add(r_cnt[K_LINES], t_len'(1));
                n_cnt[K_BYTES] = sat_add(r_cnt[K_BYTES], r_len);
                if (!s_ex.f.nonblank) begin
                    n_cnt[K_BLANK] = sat_add(r_cnt[K_BLANK], t_len'(1));
                end
                if (s_code) begin
                    n_cnt[K_CODE] = sat_add(r_cnt[K_CODE], t_len'(1));
                end
                if (s_comment) begin
                    n_cnt[K_COMMENT] = sat_add(r_cnt[K_COMMENT], t_len'(1));
                end
                if (s_code && s_comment) begin
                    n_cnt[K_BOTH] = sat_add(r_cnt[K_BOTH], t_len'(1));
                end
                if (s_code && !s_comment) begin
                    n_cnt[K_CODE_ONLY] = sat_add(r_cnt[K_CODE_ONLY], t_len'(1));
                end
                if (!s_code && s_comment) begin
                    n_cnt[K_COMMENT_ONLY] = sat_add(r_cnt[K_COMMENT_ONLY], t_len'(1));
                end
                if (r_len > r_max) begin
                    n_max = r_len;
                end
                n_held   = '0;
                n_held_v = 1'b0;
                n_len    = '0;
                n_flags  = '0;
            end else if (i_byte == CH_CR || r_flags.nul) begin
                n_len = r_len;
            end else if (i_byte == CH_NUL) begin
                n_flags.nul = 1'b1;
            end else begin
                if (r_held_v) begin
                    n_bc    = s_pair_ex.bc;
                    n_flags = s_pair_ex.f;
                    if (s_pair_ex.pair) begin
                        n_held   = '0;
                        n_held_v = 1'b0;
                    end else begin
                        n_held = i_byte;
                    end
                end else begin
                    n_held   = i_byte;
                    n_held_v = 1'b1;
                end
                n_len = r_len + t_len'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc     <= 1'b0;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_len    <= '0;
            r_flags  <= '0;
            r_cnt    <= '0;
            r_max    <= '0;
        end else begin
            r_bc     <= n_bc;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_len    <= n_len;
            r_flags  <= n_flags;
            r_cnt    <= n_cnt;
            r_max    <= n_max;
        end
    end

    assign o_totals.cnt        = r_cnt;
    assign o_totals.longest    = r_max;
    assign o_totals.block_open = r_bc;

endmodule

// ===== hw/rtl/source_line_classifier_unit.sv =====
// source line classifier top level: input register, line core, result register
// request path: input register, line core, then result register for end-of-file totals
// throughput: one request per cycle when not stalled, the line core updating on each step
// only an end-of-file request with an untaken result waiting stalls the input side
// reset (synchronous, active low) clears all counters, line state and both valid bits
module source_line_classifier_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_byte_value,
    input  logic                   i_end_of_file,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output slc_pkg::t_cnt          o_line_total,
    output slc_pkg::t_cnt          o_byte_total,
    output slc_pkg::t_cnt          o_blank_lines,
    output slc_pkg::t_cnt          o_code_lines,
    output slc_pkg::t_cnt          o_comment_lines,
    output slc_pkg::t_cnt          o_comment_only_lines,
    output slc_pkg::t_cnt          o_code_only_lines,
    output slc_pkg::t_cnt          o_code_and_comment_lines,
    output slc_pkg::t_len          o_longest_line,
    output logic                   o_block_comment_open
);
    import slc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eof;
    logic       r_out_valid;
    t_totals    r_out;
    t_totals    s_totals;
    logic       s_go;

    assign s_go       = r_in_valid && (!r_in_eof || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_byte_value;
            r_in_eof  <= i_end_of_file;
        end
    end

    slc_line_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_go),
        .i_byte   (r_in_byte),
        .i_eof    (r_in_eof),
        .o_totals (s_totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_go && r_in_eof) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && r_in_eof) begin
            r_out <= s_totals;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_line_total             = r_out.cnt[K_LINES];
    assign o_byte_total             = r_out.cnt[K_BYTES];
    assign o_blank_lines            = r_out.cnt[K_BLANK];
    assign o_code_lines             = r_out.cnt[K_CODE];
    assign o_comment_lines          = r_out.cnt[K_COMMENT];
    assign o_comment_only_lines     = r_out.cnt[K_COMMENT_ONLY];
    assign o_code_only_lines        = r_out.cnt[K_CODE_ONLY];
    assign o_code_and_comment_lines = r_out.cnt[K_BOTH];
    assign o_longest_line           = r_out.longest;
    assign o_block_comment_open     = r_out.block_open;

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_go && r_in_eof) |=> (o_out_valid && s_totals.cnt[K_LINES] == '0
                                && s_totals.longest == '0 && !s_totals.block_open))
        else $error("end of file did not publish and clear");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in_eof && r_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    a_longest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_totals.longest <= t_len'(MAX_LINE))
        else $error("longest line beyond cut length");

endmodule

// ===== tb/source_line_totals_checker.sv =====
// totals checker for source_line_classifier_unit: follows every accepted request,
// keeps its own line classification state and compares each set of totals delivered
// depends on slc_pkg for the counter types, character codes and counter indexes
module source_line_totals_checker
    import slc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [7:0] i_byte_value,
    input  logic       i_end_of_file,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  t_cnt       i_line_total,
    input  t_cnt       i_byte_total,
    input  t_cnt       i_blank_lines,
    input  t_cnt       i_code_lines,
    input  t_cnt       i_comment_lines,
    input  t_cnt       i_comment_only_lines,
    input  t_cnt       i_code_only_lines,
    input  t_cnt       i_code_and_comment_lines,
    input  t_len       i_longest_line,
    input  logic       i_block_comment_open,
    output int         o_fail_count,
    output int         o_awaited,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic       blk_open;
    logic [7:0] held_ch;
    logic       held_ok;
    t_len       run_len;
    logic       has_code;
    logic       has_cmt;
    logic       has_ink;
    logic       rest_cmt;
    logic       after_nul;
    t_cnt       tally [N_COUNTERS];
    t_len       widest;
    t_totals    totals_due [$];
    int         n_fail = 0;
    int         n_checked = 0;

    function automatic logic scan_pair(input logic [7:0] c, input logic [7:0] nxt,
                                       input logic with_next);
        logic pair;
        pair = 1'b0;
        if (blk_open) has_cmt = 1'b1;
        if (with_next && c == CH_SLASH && nxt == CH_STAR) begin
            blk_open = 1'b1;
            has_cmt  = 1'b1;
            pair     = 1'b1;
        end
        if (with_next && c == CH_STAR && nxt == CH_SLASH) begin
            blk_open = 1'b0;
            has_cmt  = 1'b1;
            pair     = 1'b1;
        end
        if (with_next && c == CH_SLASH && nxt == CH_SLASH) begin
            rest_cmt = 1'b1;
            has_cmt  = 1'b1;
            pair     = 1'b1;
        end
        if (!pair && !blk_open && !rest_cmt && c != CH_TAB && c != CH_SPACE) has_code = 1'b1;
        if (c != CH_TAB && c != CH_SPACE) has_ink = 1'b1;
        return pair;
    endfunction

    task automatic bump(input int k, input t_len amount);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, tally[k]} + (COUNT_BITS + 1)'(amount);
        tally[k] = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endtask

    task automatic clear_all();
        blk_open  = 1'b0;
        held_ch   = '0;
        held_ok   = 1'b0;
        run_len   = '0;
        has_code  = 1'b0;
        has_cmt   = 1'b0;
        has_ink   = 1'b0;
        rest_cmt  = 1'b0;
        after_nul = 1'b0;
        widest    = '0;
        for (int k = 0; k < N_COUNTERS; k++) tally[k] = '0;
    endtask

    // the held byte is the last of the line and has nothing to pair with
    task automatic close_line();
        if (held_ok) void'(scan_pair(held_ch, 8'd0, 1'b0));
        bump(K_LINES, t_len'(1));
        bump(K_BYTES, run_len);
        if (run_len > widest) widest = run_len;
        if (!has_ink) bump(K_BLANK, t_len'(1));
        if (has_code) bump(K_CODE, t_len'(1));
        if (has_cmt) bump(K_COMMENT, t_len'(1));
        if (has_code && has_cmt) bump(K_BOTH, t_len'(1));
        if (has_code && !has_cmt) bump(K_CODE_ONLY, t_len'(1));
        if (!has_code && has_cmt) bump(K_COMMENT_ONLY, t_len'(1));
        held_ch   = '0;
        held_ok   = 1'b0;
        run_len   = '0;
        has_code  = 1'b0;
        has_cmt   = 1'b0;
        has_ink   = 1'b0;
        rest_cmt  = 1'b0;
        after_nul = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_totals got;
        t_totals want;
        if (!i_rst_n) begin
            clear_all();
            totals_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.cnt[K_LINES]        = i_line_total;
                got.cnt[K_BYTES]        = i_byte_total;
                got.cnt[K_BLANK]        = i_blank_lines;
                got.cnt[K_CODE]         = i_code_lines;
                got.cnt[K_COMMENT]      = i_comment_lines;
                got.cnt[K_COMMENT_ONLY] = i_comment_only_lines;
                got.cnt[K_CODE_ONLY]    = i_code_only_lines;
                got.cnt[K_BOTH]         = i_code_and_comment_lines;
                got.longest             = i_longest_line;
                got.block_open          = i_block_comment_open;
                if (totals_due.size() == 0) begin
                    $display("%0t: totals delivered, expected none, got line_total %0d",
                             $time, got.cnt[K_LINES]);
                    n_fail++;
                end else begin
                    want = totals_due.pop_front();
                    for (int k = 0; k < N_COUNTERS; k++) begin
                        if (got.cnt[k] !== want.cnt[k]) begin
                            $display("%0t: counter %0d expected %0d, got %0d",
                                     $time, k, want.cnt[k], got.cnt[k]);
                            n_fail++;
                        end
                    end
                    if (got.longest !== want.longest) begin
                        $display("%0t: longest_line expected %0d, got %0d",
                                 $time, want.longest, got.longest);
                        n_fail++;
                    end
                    if (got.block_open !== want.block_open) begin
                        $display("%0t: block_comment_open expected %0b, got %0b",
                                 $time, want.block_open, got.block_open);
                        n_fail++;
                    end
                    n_checked++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_end_of_file) begin
                    // a partial last line is simply dropped
                    for (int k = 0; k < N_COUNTERS; k++) want.cnt[k] = tally[k];
                    want.longest    = widest;
                    want.block_open = blk_open;
                    totals_due.push_back(want);
                    clear_all();
                end else if (run_len >= MAX_LINE || i_byte_value == CH_LF) begin
                    close_line();
                end else if (i_byte_value != CH_CR && !after_nul) begin
                    if (i_byte_value == CH_NUL) begin
                        after_nul = 1'b1;
                    end else begin
                        if (!held_ok) begin
                            held_ch = i_byte_value;
                            held_ok = 1'b1;
                        end else if (scan_pair(held_ch, i_byte_value, 1'b1)) begin
                            held_ch = '0;
                            held_ok = 1'b0;
                        end else begin
                            held_ch = i_byte_value;
                        end
                        run_len++;
                    end
                end
            end
        end
        o_fail_count <= n_fail;
        o_awaited    <= totals_due.size();
        o_checked    <= n_checked;
    end

endmodule

// ===== tb/source_line_classifier_unit_test.sv =====
// top testbench for source_line_classifier_unit: clock, reset, text stimulus
// and random output stalls; checking is done by source_line_totals_checker
// depends on slc_pkg, source_line_classifier_unit and source_line_totals_checker
module source_line_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import slc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_byte_value;
    logic       i_end_of_file;
    logic       o_out_valid;
    logic       i_out_ready;
    t_cnt       o_line_total;
    t_cnt       o_byte_total;
    t_cnt       o_blank_lines;
    t_cnt       o_code_lines;
    t_cnt       o_comment_lines;
    t_cnt       o_comment_only_lines;
    t_cnt       o_code_only_lines;
    t_cnt       o_code_and_comment_lines;
    t_len       o_longest_line;
    logic       o_block_comment_open;

    int         fail_count;
    int         awaited;
    int         checked;
    int         files_sent;
    int         bytes_sent;
    logic       steady;

    source_line_classifier_unit uut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_byte_value             (i_byte_value),
        .i_end_of_file            (i_end_of_file),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_line_total             (o_line_total),
        .o_byte_total             (o_byte_total),
        .o_blank_lines            (o_blank_lines),
        .o_code_lines             (o_code_lines),
        .o_comment_lines          (o_comment_lines),
        .o_comment_only_lines     (o_comment_only_lines),
        .o_code_only_lines        (o_code_only_lines),
        .o_code_and_comment_lines (o_code_and_comment_lines),
        .o_longest_line           (o_longest_line),
        .o_block_comment_open     (o_block_comment_open)
    );

    source_line_totals_checker totals_check (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_req_valid              (i_in_valid),
        .i_req_ready              (o_in_ready),
        .i_byte_value             (i_byte_value),
        .i_end_of_file            (i_end_of_file),
        .i_res_valid              (o_out_valid),
        .i_res_ready              (i_out_ready),
        .i_line_total             (o_line_total),
        .i_byte_total             (o_byte_total),
        .i_blank_lines            (o_blank_lines),
        .i_code_lines             (o_code_lines),
        .i_comment_lines          (o_comment_lines),
        .i_comment_only_lines     (o_comment_only_lines),
        .i_code_only_lines        (o_code_only_lines),
        .i_code_and_comment_lines (o_code_and_comment_lines),
        .i_longest_line           (o_longest_line),
        .i_block_comment_open     (o_block_comment_open),
        .o_fail_count             (fail_count),
        .o_awaited                (awaited),
        .o_checked                (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("source_line_classifier_unit verification failed");
        $finish;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat (1 + idle_span()) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(40, 120)) @(posedge i_clk);
            else repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    task automatic send_request(input logic [7:0] b, input logic eof);
        int gap;
        i_in_valid    <= 1'b1;
        i_byte_value  <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (!o_in_ready);
        if (eof) files_sent++;
        else bytes_sent++;
        gap = steady ? 0 : idle_span();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
    endtask

    // hold off new requests until every set of totals has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
    endtask

    task automatic random_line(input logic ended);
        logic [7:0] line_q [$];
        int         n_tok;
        n_tok = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
        repeat (n_tok) begin
            case ($urandom_range(0, 23))
                7, 8, 9: line_q.push_back(CH_SPACE);
                10: line_q.push_back(CH_TAB);
                11: begin
                    line_q.push_back(CH_SLASH);
                    line_q.push_back(CH_STAR);
                end
                12: begin
                    line_q.push_back(CH_STAR);
                    line_q.push_back(CH_SLASH);
                end
                13: begin
                    line_q.push_back(CH_SLASH);
                    line_q.push_back(CH_SLASH);
                end
                14: line_q.push_back(CH_SLASH);
                15: line_q.push_back(CH_STAR);
                16: line_q.push_back(CH_CR);
                17: line_q.push_back(8'($urandom_range(0, 255)));
                18: line_q.push_back(8'($urandom_range(128, 255)));
                19: line_q.push_back(($urandom_range(0, 2) == 0) ? CH_NUL : 8'h61);
                default: line_q.push_back(8'($urandom_range(33, 126)));
            endcase
        end
        foreach (line_q[i]) send_request(line_q[i], 1'b0);
        if (ended) send_request(CH_LF, 1'b0);
    endtask

    // lines at and around the cut length
    task automatic long_line(input int variant);
        int         kept;
        int         tail;
        logic [7:0] stop_ch;
        kept = (variant == 3) ? MAX_LINE - 1 : (variant == 1) ? MAX_LINE - 5 : MAX_LINE;
        tail = (variant == 1) ? 20 : 0;
        repeat (kept) send_request(8'($urandom_range(32, 126)), 1'b0);
        if (tail > 0) begin
            send_request(CH_NUL, 1'b0);
            repeat (tail) send_request(8'($urandom_range(32, 126)), 1'b0);
            send_request(CH_LF, 1'b0);
        end else if (kept == MAX_LINE) begin
            case ($urandom_range(0, 3))
                0: stop_ch = CH_LF;
                1: stop_ch = CH_CR;
                2: stop_ch = CH_NUL;
                default: stop_ch = 8'($urandom_range(0, 255));
            endcase
            send_request(stop_ch, 1'b0);
        end else begin
            send_request(CH_LF, 1'b0);
        end
    endtask

    task automatic random_file(input int idx);
        int n_lines;
        n_lines = $urandom_range(0, 4);
        steady  = ($urandom_range(0, 3) == 0);
        if (idx == 5) long_line(0);
        repeat (n_lines) random_line(1'b1);
        if ($urandom_range(0, 3) == 0) random_line(1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
        if (idx == 0 || $urandom_range(0, 4) == 0) drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_byte_value  = '0;
        i_end_of_file = 1'b0;
        files_sent    = 0;
        bytes_sent    = 0;
        steady        = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty file, blank lines, orphan close, slash-slash, block across lines, NUL, block open at end of file
        send_request(8'hFF, 1'b1);
        send_text("\n \r\n\t*/\n");
        send_text("x//\n");
        send_text("/*\n*/y\n");
        send_request(CH_NUL, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(CH_LF, 1'b0);
        send_text("/*");
        send_request(8'h00, 1'b1);
        drain_results();

        for (int f = 0; f < 24; f++) random_file(f);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("run covered %0d files and %0d byte requests, %0d sets of totals compared",
                 files_sent, bytes_sent, checked);
        if (fail_count == 0) begin
            $display("source_line_classifier_unit verification clean");
        end else begin
            $display("source_line_classifier_unit verification failed");
        end
        $finish;
    end

endmodule
